[design/its_pkg.sv]
// Shared types and constants for the interpolated table sum unit.
// Depends on nothing; its_front, its_back and the top level import it.
package its_pkg;

  localparam logic [1:0] OP_GRID  = 2'd0;
  localparam logic [1:0] OP_HDR   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam int unsigned ENERGY_W = 48;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned TOTAL_W  = 40;
  localparam int unsigned FOUND_W  = 8;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned PROD_W   = ENERGY_W + VALUE_W;
  localparam int unsigned ENTRY_W  = ENERGY_W + VALUE_W;

  typedef enum logic [1:0] {
    KIND_GRID,
    KIND_HDR,
    KIND_QUERY
  } its_kind_e;

  typedef struct packed {
    its_kind_e             kind;
    logic [3:0]            slot;
    logic [9:0]            pidx;
    logic [ENERGY_W-1:0]   energy;
    logic [VALUE_W-1:0]    value;
    logic [9:0]            rid;
    logic [COUNT_W-1:0]    cnt;
    logic                  last;
  } its_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [FOUND_W-1:0] found;
  } its_result_t;

endpackage

[design/its_ram.sv]
// Generic single-port RAM with registered read data.
// Depends on nothing.
module its_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

[design/its_fifo.sv]
// Small synchronous queue used between the front and back parts and at the output.
// Depends on nothing.
module its_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [PW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule

[design/its_front.sv]
// Front part: classifies incoming items, drops ones that do nothing, clamps counts.
// Depends on its_pkg.
module its_front import its_pkg::*; #(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                push_i,
  input  logic [1:0]          op_i,
  input  logic [3:0]          slot_i,
  input  logic [9:0]          point_index_i,
  input  logic [ENERGY_W-1:0] energy_i,
  input  logic [VALUE_W-1:0]  value_i,
  input  logic [9:0]          reaction_id_i,
  input  logic [COUNT_W-1:0]  point_count_i,
  input  logic                last_term_i,
  output logic                q_push_o,
  output its_item_t           q_item_o
);

  logic slot_ok, pidx_ok, cnt_big;

  assign slot_ok = (32'(slot_i) < NUM_SLOTS);
  assign pidx_ok = (32'(point_index_i) < MAX_POINTS);
  assign cnt_big = (32'(point_count_i) > MAX_POINTS);

  always_comb begin
    q_item_o.slot   = slot_i;
    q_item_o.pidx   = point_index_i;
    q_item_o.energy = energy_i;
    q_item_o.value  = value_i;
    q_item_o.rid    = reaction_id_i;
    q_item_o.cnt    = cnt_big ? COUNT_W'(MAX_POINTS) : point_count_i;
    q_item_o.last   = last_term_i;
    q_item_o.kind   = KIND_QUERY;
    q_push_o        = 1'b0;
    unique case (op_i)
      OP_GRID: begin
        q_item_o.kind = KIND_GRID;
        q_push_o      = push_i && slot_ok && pidx_ok;
      end
      OP_HDR: begin
        q_item_o.kind = KIND_HDR;
        q_push_o      = push_i && slot_ok;
      end
      OP_QUERY: begin
        q_item_o.kind = KIND_QUERY;
        q_push_o      = push_i;
      end
      default: begin
        q_push_o = 1'b0;
      end
    endcase
  end

endmodule

[design/its_back.sv]
// Back part: table writes, slot scan, binary search, interpolation and accumulation.
// Depends on its_pkg and its_ram.
module its_back import its_pkg::*; #(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  its_item_t   q_item_i,
  output logic        q_pop_o,
  input  logic        r_full_i,
  output logic        r_push_o,
  output its_result_t r_data_o
);

  localparam int unsigned AW = $clog2(NUM_SLOTS * MAX_POINTS);
  localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned DCW = $clog2(PROD_W);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_FIRST, S_CHKF, S_CHKL, S_BS, S_BSW, S_E0, S_E1,
    S_MUL0, S_MUL1, S_DIV, S_FIN, S_ACC, S_END
  } state_e;

  state_e               state_q;
  its_item_t            item_q;
  logic [9:0]           ids_q  [NUM_SLOTS];
  logic [COUNT_W-1:0]   cnts_q [NUM_SLOTS];
  logic [SW-1:0]        scan_q;
  logic [AW-1:0]        base_q;
  logic [COUNT_W-1:0]   n_q, lo_q, hi_q, mid_q;
  logic [ENERGY_W-1:0]  e0_q, de_q, dbig_q, rem_q;
  logic [VALUE_W-1:0]   v0_q, dv_q, val_q;
  logic                 neg_q;
  logic [PROD_W-1:0]    prod_q;
  logic [DCW-1:0]       dcnt_q;
  logic [TOTAL_W-1:0]   total_q;
  logic [FOUND_W-1:0]   found_q;

  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic [ENERGY_W-1:0]  re;
  logic [VALUE_W-1:0]   rv;
  logic [COUNT_W-1:0]   idx_c, mid_c, last_idx;
  logic [COUNT_W:0]     mid_sum;
  logic [ENERGY_W:0]    rem_sh;
  logic                 rem_ge;
  logic [TOTAL_W:0]     acc_sum;

  assign re       = ram_rdata[ENTRY_W-1:VALUE_W];
  assign rv       = ram_rdata[VALUE_W-1:0];
  assign last_idx = n_q - 1'b1;
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q} + 1'b1;
  assign mid_c    = mid_sum[COUNT_W:1];
  assign rem_sh   = {rem_q, prod_q[PROD_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, dbig_q});
  assign acc_sum  = {1'b0, total_q} + (TOTAL_W+1)'(val_q);

  assign q_pop_o  = (state_q == S_IDLE) && !q_empty_i;
  assign ram_we   = q_pop_o && (q_item_i.kind == KIND_GRID);
  assign r_push_o = (state_q == S_END) && item_q.last && !r_full_i;
  assign r_data_o = '{total: total_q, found: found_q};

  always_comb begin
    unique case (state_q)
      S_CHKF:  idx_c = last_idx;
      S_BS:    idx_c = (lo_q < hi_q) ? mid_c : lo_q;
      S_E0:    idx_c = lo_q + 1'b1;
      default: idx_c = '0;
    endcase
    if (state_q == S_IDLE) begin
      ram_addr = AW'(32'(q_item_i.slot) * MAX_POINTS + 32'(q_item_i.pidx));
    end else begin
      ram_addr = base_q + AW'(idx_c);
    end
  end

  its_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_SLOTS * MAX_POINTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({q_item_i.energy, q_item_i.value}),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        ids_q[i]  <= '0;
        cnts_q[i] <= '0;
      end
      total_q <= '0;
      found_q <= '0;
      scan_q  <= '0;
      dcnt_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            item_q <= q_item_i;
            scan_q <= '0;
            if (q_item_i.kind == KIND_HDR) begin
              ids_q[SW'(q_item_i.slot)]  <= q_item_i.rid;
              cnts_q[SW'(q_item_i.slot)] <= q_item_i.cnt;
            end else if (q_item_i.kind == KIND_QUERY) begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cnts_q[scan_q] != '0 && ids_q[scan_q] == item_q.rid) begin
            n_q     <= cnts_q[scan_q];
            base_q  <= AW'(32'(scan_q) * MAX_POINTS);
            state_q <= S_FIRST;
          end else if (32'(scan_q) == NUM_SLOTS - 1) begin
            state_q <= S_END;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_FIRST: state_q <= S_CHKF;
        S_CHKF: begin
          if (item_q.energy < re) begin
            val_q   <= rv;
            state_q <= S_ACC;
          end else begin
            state_q <= S_CHKL;
          end
        end
        S_CHKL: begin
          if (item_q.energy > re) begin
            val_q   <= rv;
            state_q <= S_ACC;
          end else begin
            lo_q    <= '0;
            hi_q    <= last_idx;
            state_q <= S_BS;
          end
        end
        S_BS: begin
          mid_q   <= mid_c;
          state_q <= (lo_q < hi_q) ? S_BSW : S_E0;
        end
        S_BSW: begin
          if (re <= item_q.energy) begin
            lo_q <= mid_q;
          end else begin
            hi_q <= mid_q - 1'b1;
          end
          state_q <= S_BS;
        end
        S_E0: begin
          e0_q <= re;
          v0_q <= rv;
          if (re == item_q.energy || lo_q == last_idx) begin
            val_q   <= rv;
            state_q <= S_ACC;
          end else begin
            state_q <= S_E1;
          end
        end
        S_E1: begin
          if (re <= e0_q || item_q.energy < e0_q) begin
            val_q   <= v0_q;
            state_q <= S_ACC;
          end else begin
            neg_q   <= (rv < v0_q);
            dv_q    <= (rv < v0_q) ? v0_q - rv : rv - v0_q;
            de_q    <= item_q.energy - e0_q;
            dbig_q  <= re - e0_q;
            state_q <= S_MUL0;
          end
        end
        S_MUL0: begin
          prod_q  <= PROD_W'(64'(dv_q) * 64'(de_q[31:0]));
          state_q <= S_MUL1;
        end
        S_MUL1: begin
          prod_q  <= prod_q + {48'(dv_q * de_q[ENERGY_W-1:32]), 32'b0};
          rem_q   <= '0;
          dcnt_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q  <= rem_ge ? ENERGY_W'(rem_sh - {1'b0, dbig_q}) : ENERGY_W'(rem_sh);
          prod_q <= {prod_q[PROD_W-2:0], rem_ge};
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DCW'(PROD_W - 1)) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          val_q   <= neg_q ? v0_q - prod_q[VALUE_W-1:0] : v0_q + prod_q[VALUE_W-1:0];
          state_q <= S_ACC;
        end
        S_ACC: begin
          total_q <= acc_sum[TOTAL_W] ? '1 : acc_sum[TOTAL_W-1:0];
          if (found_q != '1) begin
            found_q <= found_q + 1'b1;
          end
          state_q <= S_END;
        end
        S_END: begin
          if (!item_q.last) begin
            state_q <= S_IDLE;
          end else if (!r_full_i) begin
            total_q <= '0;
            found_q <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[design/interpolated_table_sum_unit.sv]
// Top level of the interpolated table sum unit: front classifier, item queue,
// back execution engine and result queue. Depends on its_pkg and all its_* modules.
//
//   Channel  Handshake           Payload
//   input    push / full         op, slot, point_index, energy, value, reaction_id,
//                                point_count, last_term
//   result   empty / pop         total, terms_found
//
// Grid and header writes are done in the back part as the item is popped. A query term
// scans the slots for its reaction id; if one matches, it tests the grid ends and, for an
// energy inside the grid, runs a binary search, reads the two bracketing points and, unless
// it hits a point, multiplies in two parts and divides bit-serially over the 80-bit product.
// A two-entry queue lets the input side keep accepting while the back part works.
// Reset clears slot headers and sums; grid memory contents are undefined until written.
module interpolated_table_sum_unit import its_pkg::*; #(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          op_i,
  input  logic [3:0]          slot_i,
  input  logic [9:0]          point_index_i,
  input  logic [ENERGY_W-1:0] energy_i,
  input  logic [VALUE_W-1:0]  value_i,
  input  logic [9:0]          reaction_id_i,
  input  logic [COUNT_W-1:0]  point_count_i,
  input  logic                last_term_i,
  output logic                empty,
  input  logic                pop,
  output logic [TOTAL_W-1:0]  total_o,
  output logic [FOUND_W-1:0]  terms_found_o
);

  logic        f_push, q_empty, q_pop, r_push, r_full;
  its_item_t   f_item, q_item;
  its_result_t r_in, r_out;

  its_front #(.NUM_SLOTS(NUM_SLOTS), .MAX_POINTS(MAX_POINTS)) u_front (
    .push_i        (push && !full),
    .op_i          (op_i),
    .slot_i        (slot_i),
    .point_index_i (point_index_i),
    .energy_i      (energy_i),
    .value_i       (value_i),
    .reaction_id_i (reaction_id_i),
    .point_count_i (point_count_i),
    .last_term_i   (last_term_i),
    .q_push_o      (f_push),
    .q_item_o      (f_item)
  );

  its_fifo #(.WIDTH($bits(its_item_t)), .DEPTH(2)) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (f_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .rdata_o (q_item),
    .empty_o (q_empty)
  );

  its_back #(.NUM_SLOTS(NUM_SLOTS), .MAX_POINTS(MAX_POINTS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .r_full_i  (r_full),
    .r_push_o  (r_push),
    .r_data_o  (r_in)
  );

  its_fifo #(.WIDTH($bits(its_result_t)), .DEPTH(2)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (r_push),
    .wdata_i (r_in),
    .full_o  (r_full),
    .pop_i   (pop),
    .rdata_o (r_out),
    .empty_o (empty)
  );

  assign total_o       = r_out.total;
  assign terms_found_o = r_out.found;

endmodule

[sim/interpolated_table_sum_unit_tb.sv]
// Self-checking testbench for interpolated_table_sum_unit: loads curves, runs query terms
// and compares each emitted sum against a predictor kept in a small scoreboard class.
// Depends on its_pkg and the RTL of the unit; needs no files or arguments.
module interpolated_table_sum_unit_tb;
  import its_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned POINTS = 1024;
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam logic [TOTAL_W-1:0] TOTAL_SAT = {TOTAL_W{1'b1}};
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RANDOM_ITEMS = 300;

  typedef struct {
    logic [1:0]          op;
    logic [3:0]          slot;
    logic [9:0]          pidx;
    logic [ENERGY_W-1:0] energy;
    logic [VALUE_W-1:0]  value;
    logic [9:0]          rid;
    logic [COUNT_W-1:0]  cnt;
    logic                last;
  } term_item_t;

  class sum_scoreboard;
    logic [9:0]          ids[SLOTS];
    logic [COUNT_W-1:0]  counts[SLOTS];
    logic [ENERGY_W-1:0] grid[SLOTS*POINTS];
    logic [VALUE_W-1:0]  vals[SLOTS*POINTS];
    logic [TOTAL_W-1:0]  acc_total;
    logic [FOUND_W-1:0]  acc_found;
    its_result_t         pending[$];
    int                  errors;
    int                  checked;
    int                  queries;

    function new();
      for (int s = 0; s < SLOTS; s++) begin
        ids[s] = '0;
        counts[s] = '0;
      end
      for (int i = 0; i < SLOTS*POINTS; i++) begin
        grid[i] = '0;
        vals[i] = '0;
      end
      acc_total = '0;
      acc_found = '0;
      errors = 0;
      checked = 0;
      queries = 0;
    endfunction

    function logic [VALUE_W-1:0] interp(int s, logic [ENERGY_W-1:0] e);
      int base, n, lo, hi, mid;
      logic [ENERGY_W-1:0] e0, e1;
      logic [VALUE_W-1:0] v0, v1, dv;
      logic [PROD_W-1:0] prod, quo;
      base = s * POINTS;
      n = counts[s];
      if (e < grid[base]) return vals[base];
      if (e > grid[base+n-1]) return vals[base+n-1];
      lo = 0;
      hi = n - 1;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (grid[base+mid] <= e) lo = mid;
        else hi = mid - 1;
      end
      e0 = grid[base+lo];
      v0 = vals[base+lo];
      if (e0 == e || lo == n - 1) return v0;
      e1 = grid[base+lo+1];
      if (e1 <= e0 || e < e0) return v0;
      v1 = vals[base+lo+1];
      dv = (v1 >= v0) ? v1 - v0 : v0 - v1;
      prod = PROD_W'(dv) * PROD_W'(e - e0);
      quo = prod / PROD_W'(e1 - e0);
      return (v1 >= v0) ? v0 + quo[VALUE_W-1:0] : v0 - quo[VALUE_W-1:0];
    endfunction

    function void note(term_item_t it);
      logic [TOTAL_W:0] sum;
      its_result_t res;
      case (it.op)
        OP_GRID: begin
          grid[it.slot*POINTS+it.pidx] = it.energy;
          vals[it.slot*POINTS+it.pidx] = it.value;
        end
        OP_HDR: begin
          ids[it.slot] = it.rid;
          counts[it.slot] = (it.cnt > POINTS) ? COUNT_W'(POINTS) : it.cnt;
        end
        OP_QUERY: begin
          queries++;
          for (int s = 0; s < SLOTS; s++) begin
            if (counts[s] != 0 && ids[s] == it.rid) begin
              sum = {1'b0, acc_total} + (TOTAL_W+1)'(interp(s, it.energy));
              acc_total = (sum > TOTAL_SAT) ? TOTAL_SAT : sum[TOTAL_W-1:0];
              if (acc_found != 8'hFF) acc_found++;
              break;
            end
          end
          if (it.last) begin
            res.total = acc_total;
            res.found = acc_found;
            pending.push_back(res);
            acc_total = '0;
            acc_found = '0;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check(logic [TOTAL_W-1:0] total, logic [FOUND_W-1:0] found);
      its_result_t exp_res;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result total=%h found=%0d", total, found));
      end else begin
        exp_res = pending.pop_front();
        checked++;
        if (total !== exp_res.total)
          report($sformatf("total %h, expected %h", total, exp_res.total));
        if (found !== exp_res.found)
          report($sformatf("terms_found %0d, expected %0d", found, exp_res.found));
      end
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic [1:0]          op_i = OP_NOP;
  logic [3:0]          slot_i = '0;
  logic [9:0]          point_index_i = '0;
  logic [ENERGY_W-1:0] energy_i = '0;
  logic [VALUE_W-1:0]  value_i = '0;
  logic [9:0]          reaction_id_i = '0;
  logic [COUNT_W-1:0]  point_count_i = '0;
  logic                last_term_i = 1'b0;
  logic                empty;
  logic                pop = 1'b0;
  logic [TOTAL_W-1:0]  total_o;
  logic [FOUND_W-1:0]  terms_found_o;

  sum_scoreboard sb = new();
  bit  written[SLOTS*POINTS];
  int  send_idle_pct = 30;
  int  recv_idle_pct = 63;
  int  hold_left = 0;
  int  cycles = 0;
  int  items_sent = 0;

  interpolated_table_sum_unit uut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("interpolated_table_sum_unit_tb failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (pop && !empty) sb.check(total_o, terms_found_o);
  end

  task automatic send(term_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push = 1'b1;
    op_i = it.op;
    slot_i = it.slot;
    point_index_i = it.pidx;
    energy_i = it.energy;
    value_i = it.value;
    reaction_id_i = it.rid;
    point_count_i = it.cnt;
    last_term_i = it.last;
    do @(posedge clk_i); while (full);
    sb.note(it);
    items_sent++;
    if (it.op == OP_GRID) written[it.slot*POINTS+it.pidx] = 1'b1;
  endtask

  function automatic term_item_t blank(logic [1:0] op);
    term_item_t it;
    it.op = op;
    it.slot = 4'($urandom);
    it.pidx = 10'($urandom);
    it.energy = {16'($urandom), 32'($urandom)};
    it.value = $urandom;
    it.rid = 10'($urandom);
    it.cnt = 11'($urandom);
    it.last = 1'($urandom);
    return it;
  endfunction

  task automatic write_point(int s, int idx, logic [ENERGY_W-1:0] e, logic [VALUE_W-1:0] v);
    term_item_t it;
    it = blank(OP_GRID);
    it.slot = 4'(s);
    it.pidx = 10'(idx);
    it.energy = e;
    it.value = v;
    send(it);
  endtask

  task automatic write_header(int s, int id, int n);
    term_item_t it;
    it = blank(OP_HDR);
    it.slot = 4'(s);
    it.rid = 10'(id);
    it.cnt = 11'(n);
    send(it);
  endtask

  task automatic query(int id, logic [ENERGY_W-1:0] e, bit last);
    term_item_t it;
    it = blank(OP_QUERY);
    it.rid = 10'(id);
    it.energy = e;
    it.last = last;
    send(it);
  endtask

  task automatic load_curve(int s, int id, int n, bit ordered);
    logic [ENERGY_W-1:0] e;
    e = ($urandom_range(3) == 0) ? {16'($urandom), 32'($urandom)} : ENERGY_W'($urandom);
    for (int i = 0; i < n; i++) begin
      write_point(s, i, e, ($urandom_range(4) == 0) ? VALUE_W'($urandom_range(3)) : $urandom);
      if (ordered) e = e + ENERGY_W'($urandom_range(1 << 20));
      else e = {16'($urandom), 32'($urandom)};
    end
    write_header(s, id, n);
  endtask

  function automatic int written_prefix(int s);
    int n;
    n = 0;
    while (n < POINTS && written[s*POINTS+n]) n++;
    return n;
  endfunction

  function automatic logic [ENERGY_W-1:0] pick_energy(int id);
    int s, n, k;
    logic [ENERGY_W-1:0] e;
    for (s = 0; s < SLOTS; s++)
      if (sb.counts[s] != 0 && sb.ids[s] == id) break;
    if (s == SLOTS || $urandom_range(9) == 0) return {16'($urandom), 32'($urandom)};
    n = sb.counts[s];
    k = $urandom_range(n - 1);
    e = sb.grid[s*POINTS+k];
    case ($urandom_range(4))
      0: return e;
      1: return e + ENERGY_W'($urandom_range(1 << 19));
      2: return sb.grid[s*POINTS] - ENERGY_W'($urandom_range(1000));
      3: return sb.grid[s*POINTS+n-1] + ENERGY_W'($urandom_range(1000));
      default: return e + ENERGY_W'($urandom);
    endcase
  endfunction

  task automatic query_batch(int terms);
    int id;
    for (int t = 0; t < terms; t++) begin
      id = ($urandom_range(4) == 0) ? $urandom_range(1023) : sb.ids[$urandom_range(SLOTS-1)];
      query(id, pick_energy(id), t == terms - 1);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    push = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(int count);
    int target, r, s, p;
    term_item_t it;
    target = items_sent + count;
    while (items_sent < target) begin
      r = $urandom_range(99);
      s = $urandom_range(SLOTS - 2);
      if (r < 12) begin
        load_curve(s, $urandom_range(7), ($urandom_range(19) == 0) ? $urandom_range(40)
                   : $urandom_range(1, 8), $urandom_range(9) != 0);
      end else if (r < 20) begin
        write_point(s, $urandom_range(POINTS - 1), {16'($urandom), 32'($urandom)}, $urandom);
      end else if (r < 26) begin
        p = written_prefix(s);
        write_header(s, ($urandom_range(1) == 0) ? $urandom_range(7) : $urandom_range(1023),
                     $urandom_range(p));
      end else if (r < 29) begin
        it = blank(OP_NOP);
        send(it);
      end else begin
        query_batch($urandom_range(1, 5));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: one ordered curve with rising and falling segments, duplicate ids,
    // an empty slot, a disordered grid and an extreme single point.
    write_point(0, 0, 100, 1000);
    write_point(0, 1, 200, 500);
    write_point(0, 2, 300, 32'hFFFF_FFFF);
    write_point(0, 3, 400, 0);
    write_header(0, 5, 4);
    write_point(1, 0, 150, 7);
    write_header(1, 5, 1);
    write_point(2, 0, {ENERGY_W{1'b1}}, 32'hFFFF_FFFF);
    write_header(2, 1023, 1);
    write_header(3, 9, 0);
    write_point(4, 0, 300, 10);
    write_point(4, 1, 100, 20);
    write_point(4, 2, 200, 30);
    write_header(4, 7, 3);
    query(5, 50, 0);
    query(5, 200, 0);
    query(5, 150, 0);
    query(5, 250, 0);
    query(5, 500, 1);
    query(5, 400, 0);
    query(9, 200, 0);
    query(1023, {ENERGY_W{1'b1}}, 0);
    query(7, 250, 0);
    query(7, 350, 1);
    send(blank(OP_NOP));

    // An oversized count queried below its first point, then the slot is emptied again.
    // A long run of terms then saturates both sums.
    write_point(15, 0, 1000, 77);
    write_point(15, 1, 2000, 99);
    write_header(15, 0, 2047);
    query(0, 500, 1);
    write_header(15, 0, 0);
    write_point(5, 0, 0, 32'hFFFF_FFFF);
    write_header(5, 2, 1);
    for (int i = 0; i < 260; i++) query(2, $urandom_range(9), i == 259);
    drain();

    random_phase(RANDOM_ITEMS / 3);
    drain();
    send_idle_pct = 63;
    recv_idle_pct = 30;
    random_phase(RANDOM_ITEMS / 3);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 3000;
    for (int i = 0; i < 30; i++) query_batch(1);
    random_phase(RANDOM_ITEMS / 3);
    drain();
    repeat (400) @(posedge clk_i);

    $display("Sent %0d items with %0d query terms; %0d sums checked over %0d cycles.",
             items_sent, sb.queries, sb.checked, cycles);
    $display("Covered interpolation, grid hits, end clamps, empty and unknown ids, saturation.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("interpolated_table_sum_unit_tb passed");
    end else begin
      $display("%0d mismatches, %0d sums missing", sb.errors, sb.pending.size());
      $display("interpolated_table_sum_unit_tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/its_pkg.sv
design/its_ram.sv
design/its_fifo.sv
design/its_front.sv
design/its_back.sv
design/interpolated_table_sum_unit.sv
sim/interpolated_table_sum_unit_tb.sv
